### rtl/core/cmlut_pkg.sv
// Shared constants and types of the colormap lookup mapper.
`timescale 1ns / 1ps

package cmlut_pkg;

  // Color table size and derived widths
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int COMP_W   = 8;
  localparam int COLOR_W  = 32;
  localparam int POS_W    = 8;
  localparam int ENT_W    = 9;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Scaled difference (diff * (n - 1)) and compare width for the entry count
  localparam int PROD_W = SAMPLE_W + IDX_W;
  localparam int CNT_W  = (ENT_W > IDX_W + 1) ? ENT_W : IDX_W + 1;

  // Pipeline: capture, clamp, subtract, multiply, then one quotient bit per stage
  localparam int NSTG = 4 + IDX_W;

  // Operation codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MAP  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd2;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] LOW_BOUND_RST      = 32'sd0;
  localparam logic [SAMPLE_W-1:0] HIGH_BOUND_RST     = 32'sd65536;
  localparam logic [ENT_W-1:0]    ENTRIES_IN_USE_RST = 9'd256;

  // Payload of one pipeline stage
  typedef struct packed {
    logic               is_map;
    logic [POS_W-1:0]   widx;
    logic [COLOR_W-1:0] wcolor;
    logic [PROD_W-1:0]  rem;
    logic [IDX_W-1:0]   quo;
  } stage_t;

endpackage

### rtl/core/cmlut_if.sv
// Valid/ready channel interfaces for input items and color results.
`timescale 1ns / 1ps

interface cmlut_in_if import cmlut_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [POS_W-1:0]           entry_index;
  logic [COMP_W-1:0]          red;
  logic [COMP_W-1:0]          green;
  logic [COMP_W-1:0]          blue;
  logic [COMP_W-1:0]          alpha;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (
    output valid, func, entry_index, red, green, blue, alpha, sample,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, red, green, blue, alpha, sample,
    output ready
  );
endinterface

interface cmlut_out_if import cmlut_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;

  modport source (output valid, color, input ready);
  modport sink (input valid, color, output ready);
endinterface

### rtl/core/colormap_lut_mapper_unit.sv
// Top level of the colormap lookup mapper: clamp, scale, divide and table read.
`timescale 1ns / 1ps

// Pseudocolor mapper. Load items (func 0) write one packed color word (alpha, red,
// green, blue from high byte to low) into the color table and give no result; map
// items (func 1) clamp a signed Q16.16 sample to [low_bound, high_bound], compute
// floor((clamped - low_bound) * (n - 1) / (high_bound - low_bound)) exactly, with n
// = entries_in_use held to 1..256, and return that entry's color (entry 0 when
// high_bound <= low_bound). It takes one item per clock while the result side is
// not stalled. A map item passes one capture stage, a clamp stage, a subtract stage,
// a 32 x 8 multiply stage, then a restoring divider that resolves one quotient bit
// per stage, and the registered read of the table RAM. Loads travel the same
// pipeline and write the RAM at the read stage, so every map sees exactly the loads
// accepted before it. The user must write configuration only while the block is
// idle (not enforced); table entries must be loaded before they are mapped.

module colormap_lut_mapper_unit import cmlut_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  cmlut_in_if.sink             feed,
  cmlut_out_if.source          result,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int LAST = NSTG - 1;

  // Configuration registers and values derived from them
  logic signed [SAMPLE_W-1:0] low_bound;
  logic signed [SAMPLE_W-1:0] high_bound;
  logic [ENT_W-1:0]           entries_in_use;
  logic                       flat;
  logic [SAMPLE_W-1:0]        range_r;
  logic [IDX_W-1:0]           nm1;

  // Pipeline state
  stage_t          stg      [NSTG];
  stage_t          stg_next [NSTG];
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  logic            res_v;

  // Table RAM controls
  logic                ram_we;
  logic                ram_re;
  logic [COLOR_W-1:0]  ram_rdata;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound      <= LOW_BOUND_RST;
      high_bound     <= HIGH_BOUND_RST;
      entries_in_use <= ENTRIES_IN_USE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LOW_BOUND:      low_bound      <= cfg_wdata;
        REG_HIGH_BOUND:     high_bound     <= cfg_wdata;
        REG_ENTRIES_IN_USE: entries_in_use <= cfg_wdata[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Precompute range, flat flag and saturated entry count
  always_ff @(posedge clk) begin
    logic [SAMPLE_W:0] span;
    logic [CNT_W-1:0]  n_ext;
    logic [CNT_W-1:0]  n_sat;
    span  = {high_bound[SAMPLE_W-1], high_bound} - {low_bound[SAMPLE_W-1], low_bound};
    n_ext = CNT_W'(entries_in_use);
    if (n_ext == '0) begin
      n_sat = CNT_W'(1);
    end else if (n_ext > CNT_W'(TABLE_DEPTH)) begin
      n_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      n_sat = n_ext;
    end
    flat    <= !(high_bound > low_bound);
    range_r <= (high_bound > low_bound) ? span[SAMPLE_W-1:0] : SAMPLE_W'(1);
    nm1     <= IDX_W'(n_sat - CNT_W'(1));
  end

  // Ready chain: a stage moves when it is empty or the next one moves
  always_comb begin
    rdy[NSTG] = !res_v || result.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i + 1];
    end
  end

  assign feed.ready = rdy[0];

  // Stage logic
  always_comb begin
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] c;
    logic [SAMPLE_W:0]          d33;
    logic [PROD_W-1:0]          dvs;
    int                         k;

    // Capture the item
    stg_next[0].is_map = (feed.func == FUNC_MAP);
    stg_next[0].widx   = feed.entry_index;
    stg_next[0].wcolor = {feed.alpha, feed.red, feed.green, feed.blue};
    stg_next[0].rem    = PROD_W'($unsigned(feed.sample));
    stg_next[0].quo    = '0;

    // Clamp to the bounds
    s = signed'(stg[0].rem[SAMPLE_W-1:0]);
    if (s < low_bound) begin
      c = low_bound;
    end else if (s > high_bound) begin
      c = high_bound;
    end else begin
      c = s;
    end
    stg_next[1]     = stg[0];
    stg_next[1].rem = PROD_W'($unsigned(c));

    // Offset from the low bound, zero for a flat range
    d33 = {stg[1].rem[SAMPLE_W-1], stg[1].rem[SAMPLE_W-1:0]}
        - {low_bound[SAMPLE_W-1], low_bound};
    stg_next[2]     = stg[1];
    stg_next[2].rem = flat ? '0 : PROD_W'(d33[SAMPLE_W-1:0]);

    // Scale by entries in use minus one
    stg_next[3]     = stg[2];
    stg_next[3].rem = PROD_W'(stg[2].rem[SAMPLE_W-1:0]) * PROD_W'(nm1);

    // Restoring divide, one quotient bit per stage from the top
    for (int j = 0; j < IDX_W; j++) begin
      k = IDX_W - 1 - j;
      dvs = PROD_W'(range_r) << k;
      stg_next[4 + j] = stg[3 + j];
      if (stg[3 + j].rem >= dvs) begin
        stg_next[4 + j].rem    = stg[3 + j].rem - dvs;
        stg_next[4 + j].quo[k] = 1'b1;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= feed.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i - 1];
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  // Write loads and read maps at the table stage
  assign ram_we = vld[LAST] && !stg[LAST].is_map && rdy[NSTG]
               && (32'(stg[LAST].widx) < TABLE_DEPTH);
  assign ram_re = vld[LAST] && stg[LAST].is_map && rdy[NSTG];

  cmlut_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(stg[LAST].widx)),
    .wdata (stg[LAST].wcolor),
    .re    (ram_re),
    .raddr (stg[LAST].quo),
    .rdata (ram_rdata)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (rdy[NSTG]) begin
      res_v <= vld[LAST] && stg[LAST].is_map;
    end
  end

  assign result.valid = res_v;
  assign result.color = ram_rdata;

  // Checks
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table written and read in the same cycle");

  a_index_in_use: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && stg[LAST].is_map) |-> (stg[LAST].quo <= nm1))
    else $error("table index beyond entries in use");

  a_rem_below_range: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && stg[LAST].is_map) |-> (stg[LAST].rem < PROD_W'(range_r)))
    else $error("divider remainder not below range");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && !stg[LAST].is_map && rdy[NSTG]) |=> !result.valid)
    else $error("load item produced a result");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> result.valid)
    else $error("table read without a result");

endmodule

### rtl/core/cmlut_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cmlut_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### dv/tb_colormap_lut_mapper_unit.sv
// Self-checking testbench of the colormap lookup mapper: table loads, sample maps, config sweep.
`timescale 1ns / 1ps

module tb_colormap_lut_mapper_unit import cmlut_pkg::*; ();

  localparam int HALF_PERIOD  = 10;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = NSTG + 6;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 200;
  localparam int MAX_PRINTS   = 30;

  // Idling modes of a phase; mode zero idles neither side
  localparam int MODE_SEND = 1;
  localparam int MODE_RECV = 2;
  localparam int MODE_BOTH = 3;

  // Predicts colors of map items from its own copy of the table and registers
  class color_scoreboard;
    logic [COLOR_W-1:0]         lut [TABLE_DEPTH];
    bit                         written [TABLE_DEPTH];
    logic signed [SAMPLE_W-1:0] low_b;
    logic signed [SAMPLE_W-1:0] high_b;
    logic [ENT_W-1:0]           ents;
    logic [COLOR_W-1:0]         expected_colors [$];
    int unsigned                errors;
    int unsigned                loads;
    int unsigned                maps;
    int unsigned                checked;

    function new();
      low_b   = LOW_BOUND_RST;
      high_b  = HIGH_BOUND_RST;
      ents    = ENTRIES_IN_USE_RST;
      errors  = 0;
      loads   = 0;
      maps    = 0;
      checked = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_LOW_BOUND:      low_b = data;
        REG_HIGH_BOUND:     high_b = data;
        REG_ENTRIES_IN_USE: ents = data[ENT_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp, scale by the used entry count and floor-divide by the range
    function int unsigned entry_for(logic signed [SAMPLE_W-1:0] s);
      longint          lo;
      longint          hi;
      longint          c;
      longint unsigned n;
      longint unsigned diff;
      longint unsigned span;
      longint unsigned idx;
      lo  = longint'(low_b);
      hi  = longint'(high_b);
      n   = longint'(ents);
      idx = 0;
      if (n < 1) n = 1;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (hi > lo) begin
        c = longint'(s);
        if (c < lo) c = lo;
        if (c > hi) c = hi;
        diff = c - lo;
        span = hi - lo;
        idx  = diff * (n - 1) / span;
      end
      if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
      return int'(idx);
    endfunction

    function void note_item(logic f, logic [POS_W-1:0] pos, logic [COMP_W-1:0] r,
                            logic [COMP_W-1:0] g, logic [COMP_W-1:0] b,
                            logic [COMP_W-1:0] a, logic signed [SAMPLE_W-1:0] s);
      if (f == FUNC_LOAD) begin
        lut[pos]     = {a, r, g, b};
        written[pos] = 1'b1;
        loads++;
      end else begin
        expected_colors.push_back(lut[entry_for(s)]);
        maps++;
      end
    endfunction

    // Print only the first few mismatches, count all of them
    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, what);
    endtask

    task check_color(logic [COLOR_W-1:0] got);
      logic [COLOR_W-1:0] want;
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("color %08h with no map item pending", got));
      end else begin
        want = expected_colors.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("color %08h, expected %08h", got, want));
      end
    endtask

    function int unsigned pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  cmlut_in_if  feed_if ();
  cmlut_out_if res_if ();

  colormap_lut_mapper_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .feed      (feed_if.sink),
    .result    (res_if.source),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  color_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  int unsigned     cycles;

  // Clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Abort a run that stops making progress
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d colors still pending", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every accepted color
  always @(posedge clk) begin
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) sb.check_color(res_if.color);
  end

  // Offer one item, hold it until accepted; called and returning at a falling edge
  task drive_item(input logic f, input logic [POS_W-1:0] pos, input logic [COMP_W-1:0] r,
                  input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b,
                  input logic [COMP_W-1:0] a, input logic signed [SAMPLE_W-1:0] s);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      feed_if.valid = 1'b0;
      @(negedge clk);
    end
    feed_if.valid       = 1'b1;
    feed_if.func        = f;
    feed_if.entry_index = pos;
    feed_if.red         = r;
    feed_if.green       = g;
    feed_if.blue        = b;
    feed_if.alpha       = a;
    feed_if.sample      = s;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (feed_if.ready === 1'b1);
      @(negedge clk);
    end
    sb.note_item(f, pos, r, g, b, a, s);
  endtask

  task load_entry(input logic [POS_W-1:0] pos);
    drive_item(FUNC_LOAD, pos, COMP_W'($urandom), COMP_W'($urandom), COMP_W'($urandom),
               COMP_W'($urandom), SAMPLE_W'($urandom));
  endtask

  // Map a sample, loading its entry first when it was never written
  task map_value(input logic signed [SAMPLE_W-1:0] s);
    int unsigned idx;
    idx = sb.entry_for(s);
    if (!sb.written[idx]) load_entry(idx[POS_W-1:0]);
    drive_item(FUNC_MAP, POS_W'($urandom), COMP_W'($urandom), COMP_W'($urandom),
               COMP_W'($urandom), COMP_W'($urandom), s);
  endtask

  // Drop valid and hold until every pending color has come back
  task wait_drained();
    feed_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write all three registers once the block is idle
  task apply_setting(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                     input logic [ENT_W-1:0] n);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = REG_LOW_BOUND;
    cfg_wdata = lo;
    @(negedge clk);
    sb.set_reg(REG_LOW_BOUND, lo);
    cfg_index = REG_HIGH_BOUND;
    cfg_wdata = hi;
    @(negedge clk);
    sb.set_reg(REG_HIGH_BOUND, hi);
    cfg_index = REG_ENTRIES_IN_USE;
    cfg_wdata = {{(CFG_W-ENT_W){1'b0}}, n};
    @(negedge clk);
    sb.set_reg(REG_ENTRIES_IN_USE, cfg_wdata);
    cfg_wen = 1'b0;
  endtask

  // Mix of arbitrary values, the bounds, just past them and values inside the range
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    longint          lo;
    longint          hi;
    longint unsigned span;
    longint unsigned off;
    lo = longint'(sb.low_b);
    hi = longint'(sb.high_b);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return sb.low_b;
      3: return sb.high_b;
      4: return sb.low_b - 1;
      5: return sb.high_b + 1;
      default: begin
        if (hi <= lo) return SAMPLE_W'(lo + longint'($urandom_range(0, 3)));
        span = hi - lo;
        off  = {$urandom, $urandom} % (span + 1);
        return SAMPLE_W'(lo + longint'(off));
      end
    endcase
  endfunction

  // Pick register values for a phase; the first ones cover the extremes
  task phase_setting(input int p);
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] t;
    logic [ENT_W-1:0]           n;
    case (p)
      0: apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 9'd256);
      1: apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 9'd17);
      2: apply_setting(32'h0001_8000, 32'h0001_8000, 9'd256);
      3: apply_setting(32'hFFFF_0000, 32'h0001_0000, 9'd0);
      4: apply_setting(-32'sd100, 32'sd100, 9'd511);
      5: apply_setting(32'h8000_0000, 32'h8000_0001, 9'd1);
      6: apply_setting(32'h7FFF_FFFE, 32'h7FFF_FFFF, 9'd2);
      default: begin
        lo = $urandom;
        hi = $urandom;
        if (lo > hi && $urandom_range(0, 9) < 8) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
        n = ENT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(2, 8)
                                                : $urandom_range(1, 256));
        apply_setting(lo, hi, n);
      end
    endcase
  endtask

  initial begin
    int p;
    int k;
    int mode;
    sb                  = new();
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    rst                 = 1'b1;
    cfg_wen             = 1'b0;
    cfg_index           = REG_LOW_BOUND;
    cfg_wdata           = '0;
    feed_if.valid       = 1'b0;
    feed_if.func        = FUNC_LOAD;
    feed_if.entry_index = '0;
    feed_if.red         = '0;
    feed_if.green       = '0;
    feed_if.blue        = '0;
    feed_if.alpha       = '0;
    feed_if.sample      = '0;
    res_if.ready        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: edge entries, component extremes, clamping at reset bounds
    drive_item(FUNC_LOAD, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h7FFF_FFFF);
    drive_item(FUNC_LOAD, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h8000_0000);
    drive_item(FUNC_LOAD, 8'd128, 8'hFF, 8'h00, 8'hA5, 8'h5A, 32'h0);
    drive_item(FUNC_LOAD, 8'd127, 8'h00, 8'hFF, 8'h5A, 8'hA5, 32'hFFFF_FFFF);
    drive_item(FUNC_MAP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0);
    drive_item(FUNC_MAP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0001_0000);
    drive_item(FUNC_MAP, 8'h5A, 8'h12, 8'h34, 8'h56, 8'h78, 32'h8000_0000);
    drive_item(FUNC_MAP, 8'hA5, 8'h87, 8'h65, 8'h43, 8'h21, 32'h7FFF_FFFF);
    map_value(32'h0000_8000);
    map_value(32'h0000_FFFF);
    map_value(32'h0000_0100);
    map_value(32'h0000_0101);
    map_value(32'hFFFF_FFFF);
    // Overwrite an entry and read it back
    drive_item(FUNC_LOAD, 8'd0, 8'h11, 8'h22, 8'h33, 8'h44, 32'h0);
    map_value(32'h0);
    drive_item(FUNC_LOAD, 8'd255, 8'h01, 8'h80, 8'h7F, 8'hFE, 32'h0);
    map_value(32'h0001_0000);

    // Random phases over the register sweep and the idling modes
    for (p = 0; p < PHASES; p++) begin
      phase_setting(p);
      mode           = p % 4;
      send_idle_pct  = (mode == MODE_SEND) ? 72 : (mode == MODE_BOTH) ? 37 : 0;
      recv_stall_pct = (mode == MODE_RECV) ? 72 : (mode == MODE_BOTH) ? 37 : 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(0, 99) < 25) load_entry(POS_W'($urandom));
        else map_value(pick_sample());
      end
    end

    // Drain and let the pipeline settle
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d loads and %0d maps over %0d register settings", sb.loads,
             sb.maps, PHASES + 1);
    $display("Colors checked: %0d, mismatches: %0d, cycles: %0d", sb.checked, sb.errors,
             cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### colormap_lut_mapper_unit.f
rtl/core/cmlut_pkg.sv
rtl/core/cmlut_if.sv
rtl/core/cmlut_ram.sv
rtl/core/colormap_lut_mapper_unit.sv
dv/tb_colormap_lut_mapper_unit.sv
